// ===== rtl/core/register_file_alu_with_flags_top_defines.svh =====
// ----------------------------------------------------------------------------
// register_file_alu_with_flags_top_defines
// Assertion macros shared by the checker of the register file ALU.
// ----------------------------------------------------------------------------
`ifndef REGISTER_FILE_ALU_WITH_FLAGS_TOP_DEFINES_SVH
`define REGISTER_FILE_ALU_WITH_FLAGS_TOP_DEFINES_SVH

// same-cycle implication, disabled during reset
`define RFA_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rfa check failed");

// next-cycle implication, disabled during reset
`define RFA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rfa check failed");

`endif

// ===== rtl/core/rfa_pkg.sv =====
// ----------------------------------------------------------------------------
// rfa_pkg
// Types and operation codes of the register file ALU.
// ----------------------------------------------------------------------------
package rfa_pkg;

  // operation codes
  localparam logic [3:0] FUNC_ADD  = 4'd0;
  localparam logic [3:0] FUNC_SUB  = 4'd1;
  localparam logic [3:0] FUNC_AND  = 4'd2;
  localparam logic [3:0] FUNC_XOR  = 4'd3;
  localparam logic [3:0] FUNC_OR   = 4'd4;
  localparam logic [3:0] FUNC_ADDI = 4'd5;
  localparam logic [3:0] FUNC_SUBI = 4'd6;
  localparam logic [3:0] FUNC_ANDI = 4'd7;
  localparam logic [3:0] FUNC_XORI = 4'd8;
  localparam logic [3:0] FUNC_ORI  = 4'd9;
  localparam logic [3:0] FUNC_SWAP = 4'd10;
  localparam logic [3:0] FUNC_READ = 4'd11;

  // one instruction
  typedef struct packed {
    logic [3:0]         func;
    logic [4:0]         dest_index;
    logic [4:0]         src_a_index;
    logic [4:0]         src_b_index;
    logic signed [31:0] immediate;
  } instr_t;

  // one result
  typedef struct packed {
    logic signed [31:0] result_value;
    logic               overflow_flag;
    logic               negative_flag;
    logic               zero_flag;
    logic               parity_flag;
  } result_t;

  // up to two register writes per instruction (swap uses both)
  typedef struct packed {
    logic        a_en;
    logic [4:0]  a_idx;
    logic [31:0] a_data;
    logic        b_en;
    logic [4:0]  b_idx;
    logic [31:0] b_data;
  } rf_write_t;

endpackage

// ===== rtl/core/rfa_regfile.sv =====
// ----------------------------------------------------------------------------
// rfa_regfile
// Register file with three read ports and two write ports, cleared at reset.
// ----------------------------------------------------------------------------
module rfa_regfile #(
  parameter int NUM_REGS = 32
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [4:0]        rd_a_idx,
  input  logic [4:0]        rd_b_idx,
  input  logic [4:0]        rd_d_idx,
  output logic [31:0]       rd_a,
  output logic [31:0]       rd_b,
  output logic [31:0]       rd_d,
  input  rfa_pkg::rf_write_t wr
);
  import rfa_pkg::*;

  localparam int AW = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [31:0] regs [NUM_REGS];

  // reads, indexes past the end read as zero
  always_comb begin
    rd_a = (32'(rd_a_idx) < NUM_REGS) ? regs[AW'(rd_a_idx)] : '0;
    rd_b = (32'(rd_b_idx) < NUM_REGS) ? regs[AW'(rd_b_idx)] : '0;
    rd_d = (32'(rd_d_idx) < NUM_REGS) ? regs[AW'(rd_d_idx)] : '0;
  end

  // writes, port b wins on a shared index
  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_REGS; i++) begin
      if (rst) begin
        regs[i] <= '0;
      end else if (wr.b_en && (32'(wr.b_idx) == i)) begin
        regs[i] <= wr.b_data;
      end else if (wr.a_en && (32'(wr.a_idx) == i)) begin
        regs[i] <= wr.a_data;
      end
    end
  end

endmodule

// ===== rtl/core/rfa_alu.sv =====
// ----------------------------------------------------------------------------
// rfa_alu
// Operation decode, arithmetic with overflow check, and result flags.
// ----------------------------------------------------------------------------
module rfa_alu #(
  parameter int NUM_REGS = 32
) (
  input  rfa_pkg::instr_t    instr,
  input  logic [31:0]        rd_a,
  input  logic [31:0]        rd_b,
  input  logic [31:0]        rd_d,
  output rfa_pkg::rf_write_t wr,
  output rfa_pkg::result_t   result
);
  import rfa_pkg::*;

  logic [31:0] op_b;
  logic [31:0] sum;
  logic [31:0] diff;
  logic        sum_ovf;
  logic        diff_ovf;
  logic        a_in_range;
  logic [31:0] value;
  logic        ovf;

  // second operand and both arithmetic results
  always_comb begin
    op_b       = (instr.func >= FUNC_ADDI) ? $unsigned(instr.immediate) : rd_b;
    sum        = rd_a + op_b;
    diff       = rd_a - op_b;
    sum_ovf    = ~(rd_a[31] ^ op_b[31]) & (rd_a[31] ^ sum[31]);
    diff_ovf   = (rd_a[31] ^ op_b[31]) & (rd_a[31] ^ diff[31]);
    a_in_range = (32'(instr.src_a_index) < NUM_REGS);
  end

  // operation decode
  always_comb begin
    wr        = '0;
    wr.a_idx  = instr.dest_index;
    value     = rd_a;
    ovf       = 1'b0;
    unique case (instr.func) inside
      FUNC_ADD, FUNC_ADDI: begin
        ovf       = sum_ovf;
        value     = sum_ovf ? rd_d : sum;
        wr.a_en   = ~sum_ovf;
        wr.a_data = sum;
      end
      FUNC_SUB, FUNC_SUBI: begin
        ovf       = diff_ovf;
        value     = diff_ovf ? rd_d : diff;
        wr.a_en   = ~diff_ovf;
        wr.a_data = diff;
      end
      FUNC_AND, FUNC_ANDI: begin
        value     = rd_a & op_b;
        wr.a_en   = 1'b1;
        wr.a_data = value;
      end
      FUNC_XOR, FUNC_XORI: begin
        value     = rd_a ^ op_b;
        wr.a_en   = 1'b1;
        wr.a_data = value;
      end
      FUNC_OR, FUNC_ORI: begin
        value     = rd_a | op_b;
        wr.a_en   = 1'b1;
        wr.a_data = value;
      end
      FUNC_SWAP: begin
        // first swap register now holds the old second one
        wr.a_en   = 1'b1;
        wr.a_idx  = instr.src_a_index;
        wr.a_data = rd_b;
        wr.b_en   = 1'b1;
        wr.b_idx  = instr.src_b_index;
        wr.b_data = rd_a;
        value     = a_in_range ? rd_b : '0;
      end
      default: begin
        // read, and unused codes behave as read
        value = rd_a;
      end
    endcase
  end

  // flags
  always_comb begin
    result.result_value  = $signed(value);
    result.overflow_flag = ovf;
    result.negative_flag = value[31];
    result.zero_flag     = (value == '0);
    result.parity_flag   = ^value;
  end

endmodule

// ===== rtl/core/register_file_alu_with_flags_top.sv =====
// Path: input register, then decode and execute into the result register.
// Throughput: one instruction per cycle unless stalled; the register file is
// written in the same cycle as the result, so the next instruction sees it.
// Reset: synchronous, clears all registers and both stage valid flags.
// ----------------------------------------------------------------------------
// register_file_alu_with_flags_top
// Register file ALU: input register, decode and execute, result register.
// ----------------------------------------------------------------------------
module register_file_alu_with_flags_top #(
  parameter int NUM_REGS = 32
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             instr_valid,
  output logic             instr_stall,
  input  rfa_pkg::instr_t  instr,
  output logic             result_valid,
  input  logic             result_stall,
  output rfa_pkg::result_t result
);
  import rfa_pkg::*;

  logic      stage_valid;
  instr_t    stage;
  logic      advance;
  logic [31:0] rd_a;
  logic [31:0] rd_b;
  logic [31:0] rd_d;
  rf_write_t wr_req;
  rf_write_t wr_gated;
  result_t   alu_result;

  // execute when the result register is free or draining
  assign advance     = stage_valid & (~result_valid | ~result_stall);
  assign instr_stall = stage_valid & ~advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (!instr_stall) begin
      stage_valid <= instr_valid;
    end
    if (instr_valid && !instr_stall) begin
      stage <= instr;
    end
  end

  rfa_regfile #(
    .NUM_REGS(NUM_REGS)
  ) u_regfile (
    .clk      (clk),
    .rst      (rst),
    .rd_a_idx (stage.src_a_index),
    .rd_b_idx (stage.src_b_index),
    .rd_d_idx (stage.dest_index),
    .rd_a     (rd_a),
    .rd_b     (rd_b),
    .rd_d     (rd_d),
    .wr       (wr_gated)
  );

  rfa_alu #(
    .NUM_REGS(NUM_REGS)
  ) u_alu (
    .instr  (stage),
    .rd_a   (rd_a),
    .rd_b   (rd_b),
    .rd_d   (rd_d),
    .wr     (wr_req),
    .result (alu_result)
  );

  // commit writes only when the instruction retires
  always_comb begin
    wr_gated      = wr_req;
    wr_gated.a_en = wr_req.a_en & advance;
    wr_gated.b_en = wr_req.b_en & advance;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result <= alu_result;
    end
  end

endmodule

// ===== rtl/core/rfa_checker.sv =====
// ----------------------------------------------------------------------------
// rfa_checker
// Port-level checks of the register file ALU result channel.
// ----------------------------------------------------------------------------
`include "register_file_alu_with_flags_top_defines.svh"

module rfa_checker (
  input logic             clk,
  input logic             rst,
  input logic             instr_stall,
  input logic             result_valid,
  input logic             result_stall,
  input rfa_pkg::result_t result
);
  import rfa_pkg::*;

  logic held;
  assign held = result_valid & result_stall;

  // a stalled result stays put
  `RFA_ASSERT_NEXT(a_result_hold, held, result_valid && $stable(result))
  // flags agree with the value
  `RFA_ASSERT_NOW(a_zero_flag, result_valid, result.zero_flag == (result.result_value == 0))
  `RFA_ASSERT_NOW(a_neg_flag, result_valid, result.negative_flag == result.result_value[31])
  `RFA_ASSERT_NOW(a_parity_flag, result_valid, result.parity_flag == (^result.result_value))
  // input side only stalls while the result side is full
  `RFA_ASSERT_NOW(a_stall_cause, instr_stall, result_valid && result_stall)

endmodule

bind register_file_alu_with_flags_top rfa_checker u_rfa_checker (
  .clk          (clk),
  .rst          (rst),
  .instr_stall  (instr_stall),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result       (result)
);
